// File: src/msd_pkg.sv
package msd_pkg;

  localparam int SizeW     = 16;
  localparam int CharW     = 7;
  localparam int MaxSymbols = 5;
  localparam int CountW    = 3;
  localparam int IndexW    = 9;
  localparam int CfgIndexW = 2;

  localparam logic [CfgIndexW-1:0] REG_DOT_SIZE         = 2'd0;
  localparam logic [CfgIndexW-1:0] REG_LETTER_END_SIZE  = 2'd1;
  localparam logic [CfgIndexW-1:0] REG_WORD_END_SIZE    = 2'd2;
  localparam logic [CfgIndexW-1:0] REG_MESSAGE_END_SIZE = 2'd3;

  localparam logic [SizeW-1:0] DOT_SIZE_RST         = 16'd25;
  localparam logic [SizeW-1:0] LETTER_END_SIZE_RST  = 16'd45;
  localparam logic [SizeW-1:0] WORD_END_SIZE_RST    = 16'd55;
  localparam logic [SizeW-1:0] MESSAGE_END_SIZE_RST = 16'd65;

  localparam logic [CharW-1:0] CHAR_SPACE   = 7'd32;
  localparam logic [CharW-1:0] CHAR_NEWLINE = 7'd10;

  typedef struct packed {
    logic [SizeW-1:0] dot_size;
    logic [SizeW-1:0] letter_end_size;
    logic [SizeW-1:0] word_end_size;
    logic [SizeW-1:0] message_end_size;
  } msd_cfg_t;

  typedef struct packed {
    logic             message_end;
    logic             overflow;
    logic             recognized;
    logic [CharW-1:0] character;
  } msd_result_t;

  typedef struct packed {
    logic             recognized;
    logic [CharW-1:0] character;
  } msd_lookup_t;

  function automatic msd_lookup_t msd_char_lookup(input logic [IndexW-1:0] idx);
    msd_lookup_t res;
    res.recognized = 1'b1;
    case (idx)
      9'd142: res.character = 7'h61;
      9'd264: res.character = 7'h62;
      9'd328: res.character = 7'h63;
      9'd268: res.character = 7'h64;
      9'd15:  res.character = 7'h65;
      9'd72:  res.character = 7'h66;
      9'd396: res.character = 7'h67;
      9'd8:   res.character = 7'h68;
      9'd14:  res.character = 7'h69;
      9'd232: res.character = 7'h6A;
      9'd332: res.character = 7'h6B;
      9'd136: res.character = 7'h6C;
      9'd398: res.character = 7'h6D;
      9'd270: res.character = 7'h6E;
      9'd460: res.character = 7'h6F;
      9'd200: res.character = 7'h70;
      9'd424: res.character = 7'h71;
      9'd140: res.character = 7'h72;
      9'd12:  res.character = 7'h73;
      9'd271: res.character = 7'h74;
      9'd76:  res.character = 7'h75;
      9'd40:  res.character = 7'h76;
      9'd204: res.character = 7'h77;
      9'd296: res.character = 7'h78;
      9'd360: res.character = 7'h79;
      9'd392: res.character = 7'h7A;
      9'd496: res.character = 7'h30;
      9'd240: res.character = 7'h31;
      9'd112: res.character = 7'h32;
      9'd48:  res.character = 7'h33;
      9'd16:  res.character = 7'h34;
      9'd0:   res.character = 7'h35;
      9'd256: res.character = 7'h36;
      9'd384: res.character = 7'h37;
      9'd448: res.character = 7'h38;
      9'd480: res.character = 7'h39;
      default: begin
        res.recognized = 1'b0;
        res.character  = '0;
      end
    endcase
    return res;
  endfunction

endpackage

// File: src/msd_cfg_regs.sv
module msd_cfg_regs
  import msd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [SizeW-1:0]     cfg_data,
  output msd_cfg_t             cfg
);

  msd_cfg_t cfg_r;
  msd_cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_DOT_SIZE:         cfg_nxt.dot_size         = cfg_data;
        REG_LETTER_END_SIZE:  cfg_nxt.letter_end_size  = cfg_data;
        REG_WORD_END_SIZE:    cfg_nxt.word_end_size    = cfg_data;
        REG_MESSAGE_END_SIZE: cfg_nxt.message_end_size = cfg_data;
        default:              cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dot_size         <= DOT_SIZE_RST;
      cfg_r.letter_end_size  <= LETTER_END_SIZE_RST;
      cfg_r.word_end_size    <= WORD_END_SIZE_RST;
      cfg_r.message_end_size <= MESSAGE_END_SIZE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: src/msd_decode.sv
module msd_decode
  import msd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_fire,
  input  logic [SizeW-1:0] packet_size,
  input  msd_cfg_t         cfg,
  output logic             result_valid,
  output msd_result_t      result
);

  logic [MaxSymbols-1:0] symbol_bits_r;
  logic [MaxSymbols-1:0] symbol_bits_nxt;
  logic [CountW-1:0]     symbol_count_r;
  logic [CountW-1:0]     symbol_count_nxt;
  logic                  too_many_r;
  logic                  too_many_nxt;

  logic                  is_letter_end;
  logic                  is_word_end;
  logic                  is_message_end;
  logic                  is_dot;
  logic [3:0]            fill_ones;
  logic [IndexW-1:0]     letter_idx;
  msd_lookup_t           lookup;

  assign is_letter_end  = (packet_size == cfg.letter_end_size);
  assign is_word_end    = (packet_size == cfg.word_end_size);
  assign is_message_end = (packet_size == cfg.message_end_size);
  assign is_dot         = (packet_size == cfg.dot_size);

  always_comb begin
    case (symbol_count_r)
      3'd0:    fill_ones = 4'b1111;
      3'd1:    fill_ones = 4'b1111;
      3'd2:    fill_ones = 4'b1110;
      3'd3:    fill_ones = 4'b1100;
      3'd4:    fill_ones = 4'b1000;
      default: fill_ones = 4'b0000;
    endcase
  end

  assign letter_idx = {symbol_bits_r, fill_ones};
  assign lookup     = msd_char_lookup(letter_idx);

  assign result_valid = is_letter_end | is_word_end | is_message_end;

  always_comb begin
    result = '0;
    if (is_letter_end) begin
      result.character  = lookup.character;
      result.recognized = lookup.recognized;
      result.overflow   = too_many_r;
    end else if (is_word_end) begin
      result.character = CHAR_SPACE;
    end else begin
      result.character   = CHAR_NEWLINE;
      result.message_end = 1'b1;
    end
  end

  always_comb begin
    symbol_bits_nxt  = symbol_bits_r;
    symbol_count_nxt = symbol_count_r;
    too_many_nxt     = too_many_r;
    if (item_fire) begin
      if (is_letter_end || (!is_word_end && is_message_end)) begin
        symbol_bits_nxt  = '0;
        symbol_count_nxt = '0;
        too_many_nxt     = 1'b0;
      end else if (!is_word_end) begin
        if (symbol_count_r >= CountW'(MaxSymbols)) begin
          too_many_nxt = 1'b1;
        end else begin
          if (!is_dot) begin
            symbol_bits_nxt = symbol_bits_r |
                              (MaxSymbols'(1 << (MaxSymbols - 1)) >> symbol_count_r);
          end
          symbol_count_nxt = symbol_count_r + CountW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      symbol_bits_r  <= '0;
      symbol_count_r <= '0;
      too_many_r     <= 1'b0;
    end else begin
      symbol_bits_r  <= symbol_bits_nxt;
      symbol_count_r <= symbol_count_nxt;
      too_many_r     <= too_many_nxt;
    end
  end

endmodule

// File: src/morse_symbol_decoder.sv
// Inputs wait in the input register; results are offered from the result register.
// Throughput: one input transaction per cycle; the input register and the result
// register advance together whenever the result register is empty or being drained.
// Reset (rst_n, synchronous, active low) restores the size registers to their defaults
// and clears the symbol store, the overflow flag and both pipeline valid flags.
module morse_symbol_decoder
  import msd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [SizeW-1:0]     in_tdata,   // [15:0] packet_size
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [7:0]           out_tdata,  // [6:0] character, [7] zero
  output logic [1:0]           out_tuser,  // [0] recognized, [1] overflow
  output logic                 out_tlast,  // message_end
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [SizeW-1:0]     cfg_data
);

  msd_cfg_t         cfg;
  logic             stage_valid_r;
  logic             stage_valid_nxt;
  logic [SizeW-1:0] stage_size_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  msd_result_t      out_item_r;
  logic             advance;
  logic             item_fire;
  logic             result_valid;
  msd_result_t      result;

  msd_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign advance   = !out_valid_r || out_tready;
  assign item_fire = stage_valid_r && advance;
  assign in_tready = !stage_valid_r || advance;

  msd_decode u_decode (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_fire    (item_fire),
    .packet_size  (stage_size_r),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result       (result)
  );

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (in_tready) begin
      stage_valid_nxt = in_tvalid;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = stage_valid_r && result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stage_size_r <= in_tdata;
    end
    if (item_fire && result_valid) begin
      out_item_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_item_r.character};
  assign out_tuser  = {out_item_r.overflow, out_item_r.recognized};
  assign out_tlast  = out_item_r.message_end;

endmodule

// File: tb/sv/tb_morse_symbol_decoder.sv
module tb_morse_symbol_decoder;
  import msd_pkg::*;

  // Letter indexes of the character table, in the order a..z, 0..9.
  localparam int CODE_INDEX [36] = '{
    142, 264, 328, 268, 15, 72, 396, 8, 14, 232, 332, 136, 398,
    270, 460, 200, 424, 140, 12, 271, 76, 40, 204, 296, 360, 392,
    496, 240, 112, 48, 16, 0, 256, 384, 448, 480
  };

  localparam logic [SizeW-1:0] OPENING_SIZES [19] = '{
    16'd45,
    16'd65535, 16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd45,
    16'd25, 16'd25, 16'd0, 16'd0, 16'd45,
    16'd25, 16'd55, 16'd45,
    16'd0, 16'd65, 16'd45
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [SizeW-1:0]     in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic [1:0]           out_tuser;
  logic                 out_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [SizeW-1:0]     cfg_data = '0;

  logic [SizeW-1:0] pending_sizes [$];
  msd_result_t      expected_chars [$];
  msd_cfg_t         size_regs = '{DOT_SIZE_RST, LETTER_END_SIZE_RST, WORD_END_SIZE_RST,
                                  MESSAGE_END_SIZE_RST};
  logic [4:0]       sym_bits = '0;
  logic [2:0]       sym_count = '0;
  logic             sym_overflow = 1'b0;
  bit               no_idle = 1'b0;
  int               in_gap = 0;
  int               out_stall = 0;
  int               out_draw;
  int               mismatches = 0;

  morse_symbol_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic decode_packet(input logic [SizeW-1:0] size);
    msd_result_t      res;
    bit               has_char;
    int               fill;
    int               ones;
    logic [IndexW-1:0] idx;
    res = '0;
    has_char = 1'b1;
    if (size == size_regs.letter_end_size) begin
      fill = MaxSymbols - int'(sym_count);
      if (fill > 4) begin
        fill = 4;
      end
      ones = ((1 << fill) - 1) << (4 - fill);
      idx = {sym_bits, ones[3:0]};
      for (int i = 0; i < 36; i++) begin
        if (CODE_INDEX[i] == int'(idx)) begin
          res.recognized = 1'b1;
          res.character = (i < 26) ? CharW'(8'h61 + i) : CharW'(8'h30 + i - 26);
        end
      end
      res.overflow = sym_overflow;
      sym_bits = '0;
      sym_count = '0;
      sym_overflow = 1'b0;
    end else if (size == size_regs.word_end_size) begin
      res.character = CHAR_SPACE;
    end else if (size == size_regs.message_end_size) begin
      res.character = CHAR_NEWLINE;
      res.message_end = 1'b1;
      sym_bits = '0;
      sym_count = '0;
      sym_overflow = 1'b0;
    end else begin
      has_char = 1'b0;
      if (sym_count >= MaxSymbols) begin
        sym_overflow = 1'b1;
      end else begin
        if (size != size_regs.dot_size) begin
          sym_bits[4 - sym_count] = 1'b1;
        end
        sym_count++;
      end
    end
    if (has_char) begin
      expected_chars.push_back(res);
    end
  endtask

  task automatic check_char();
    msd_result_t exp_res;
    if (expected_chars.size() == 0) begin
      report_mismatch($sformatf("unexpected result, char %0d", out_tdata[6:0]));
    end else begin
      exp_res = expected_chars.pop_front();
      if (out_tdata != {1'b0, exp_res.character}) begin
        report_mismatch($sformatf("character %0d, expected %0d", out_tdata,
                                  exp_res.character));
      end
      if (out_tuser[0] != exp_res.recognized) begin
        report_mismatch($sformatf("recognized %0b, expected %0b", out_tuser[0],
                                  exp_res.recognized));
      end
      if (out_tuser[1] != exp_res.overflow) begin
        report_mismatch($sformatf("overflow %0b, expected %0b", out_tuser[1],
                                  exp_res.overflow));
      end
      if (out_tlast != exp_res.message_end) begin
        report_mismatch($sformatf("message end %0b, expected %0b", out_tlast,
                                  exp_res.message_end));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_packet(in_tdata);
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap != 0) begin
          in_tvalid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (pending_sizes.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= pending_sizes.pop_front();
          in_gap <= no_idle ? 0 : $urandom_range(0, 6);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall <= 0;
    end else if (out_tvalid && out_tready) begin
      check_char();
      out_draw = no_idle ? 0 : $urandom_range(0, 6);
      out_stall <= out_draw;
      out_tready <= (out_draw == 0);
    end else if (out_stall != 0) begin
      out_stall <= out_stall - 1;
      out_tready <= (out_stall == 1);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [SizeW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DOT_SIZE:         size_regs.dot_size = value;
      REG_LETTER_END_SIZE:  size_regs.letter_end_size = value;
      REG_WORD_END_SIZE:    size_regs.word_end_size = value;
      REG_MESSAGE_END_SIZE: size_regs.message_end_size = value;
      default: ;
    endcase
  endtask

  task automatic set_sizes(input logic [SizeW-1:0] dot, input logic [SizeW-1:0] letter_end,
                           input logic [SizeW-1:0] word_end,
                           input logic [SizeW-1:0] message_end);
    write_reg(REG_DOT_SIZE, dot);
    write_reg(REG_LETTER_END_SIZE, letter_end);
    write_reg(REG_WORD_END_SIZE, word_end);
    write_reg(REG_MESSAGE_END_SIZE, message_end);
    @(negedge clk);
  endtask

  function automatic logic [SizeW-1:0] pick_dash();
    logic [SizeW-1:0] v;
    do begin
      case ($urandom_range(0, 9))
        0:       v = '0;
        1:       v = '1;
        default: v = SizeW'($urandom_range(0, 65535));
      endcase
    end while (v == size_regs.dot_size || v == size_regs.letter_end_size ||
               v == size_regs.word_end_size || v == size_regs.message_end_size);
    return v;
  endfunction

  // Mostly whole letters with random symbols, some word and message ends, some noise.
  task automatic queue_random(input int n_items);
    int target;
    int kind;
    int n_sym;
    target = pending_sizes.size() + n_items;
    while (pending_sizes.size() < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        kind = $urandom_range(0, 99);
        n_sym = (kind < 5) ? 0 : (kind < 90) ? $urandom_range(1, 5) : $urandom_range(6, 8);
        repeat (n_sym) begin
          pending_sizes.push_back($urandom_range(0, 1) ? size_regs.dot_size : pick_dash());
        end
        pending_sizes.push_back(size_regs.letter_end_size);
        if ($urandom_range(0, 3) == 0) begin
          pending_sizes.push_back(size_regs.word_end_size);
        end
      end else if (kind < 83) begin
        pending_sizes.push_back(size_regs.word_end_size);
      end else if (kind < 88) begin
        pending_sizes.push_back(size_regs.message_end_size);
      end else begin
        pending_sizes.push_back(SizeW'($urandom_range(0, 65535)));
      end
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_sizes.size() != 0 || in_tvalid || expected_chars.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (OPENING_SIZES[i]) begin
      pending_sizes.push_back(OPENING_SIZES[i]);
    end
    queue_random(100);
    wait_idle();
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_sizes(16'd0, 16'hFFFF, 16'd1, 16'd2);
        1: set_sizes(16'hFFFF, 16'd0, 16'h8000, 16'h7FFF);
        2: set_sizes(16'd100, 16'd100, 16'd100, 16'd100);
        3: set_sizes(16'd400, 16'd300, 16'd300, 16'd400);
        4: set_sizes(16'd11, 16'd9, 16'd7, 16'd7);
        5: set_sizes(SizeW'($urandom_range(0, 65535)), SizeW'($urandom_range(0, 65535)),
                     SizeW'($urandom_range(0, 65535)), SizeW'($urandom_range(0, 65535)));
        default: set_sizes(DOT_SIZE_RST, LETTER_END_SIZE_RST, WORD_END_SIZE_RST,
                           MESSAGE_END_SIZE_RST);
      endcase
      no_idle = ($urandom_range(0, 2) == 0);
      queue_random(70);
      wait_idle();
    end
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb_morse_symbol_decoder: done, clean");
    end else begin
      $display("tb_morse_symbol_decoder: done, errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_morse_symbol_decoder: done, errors");
    $finish;
  end

endmodule
